FILE: sv/timecode_datetime_counter_macros.svh
// Assertion macros used by the checker file.
`ifndef TIMECODE_DATETIME_COUNTER_MACROS_SVH
`define TIMECODE_DATETIME_COUNTER_MACROS_SVH

// Property checked on every rising edge outside reset.
`define TDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define TDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/tdc_pkg.sv
package tdc_pkg;

  typedef enum logic [1:0] {
    REQ_FWD  = 2'd0,
    REQ_BACK = 2'd1,
    REQ_LOAD = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  localparam logic [3:0] CFG_FPS  = 4'd0;
  localparam logic [3:0] CFG_DROP = 4'd1;

  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] YEAR_RESET = 14'd2000;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // hour sits in the lowest bits, day in the highest
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  frame;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
  } tc_state_t;

  typedef struct packed {
    logic [6:0] fps;
    logic       drop;
  } tc_cfg_t;

endpackage

FILE: sv/tdc_step.sv
module tdc_step (
  input  tdc_pkg::tc_state_t cur_i,
  input  tdc_pkg::req_e      req_i,
  input  tdc_pkg::tc_state_t load_i,
  input  tdc_pkg::tc_cfg_t   cfg_i,
  output tdc_pkg::tc_state_t nxt_o,
  output logic               carry_o
);
  import tdc_pkg::*;

  function automatic logic min_tens(input logic [5:0] m);
    return (m == 6'd0) || (m == 6'd10) || (m == 6'd20) || (m == 6'd30) ||
           (m == 6'd40) || (m == 6'd50) || (m == 6'd60);
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    if (m < 4'd1 || m > 4'd12) d = 5'd31;
    else if (m == 4'd2 && leap) d = 5'd29;
    else d = MONTH_DAYS[m - 4'd1];
    return d;
  endfunction

  logic [6:0]  rate;
  logic [25:0] prod;
  logic [9:0]  quo;
  logic [13:0] quo25;
  logic [13:0] rem_raw;
  logic [5:0]  rem;
  logic        leap;
  logic [7:0]  f_inc;
  logic [6:0]  s_inc;
  logic [6:0]  m_inc;
  logic [5:0]  h_inc;
  logic [5:0]  d_inc;
  logic [4:0]  mo_inc;
  logic [4:0]  mo_sum;
  logic [3:0]  mo_back;
  logic        skip;
  logic        wrap;
  tc_state_t   t;

  assign rate = (cfg_i.fps == 7'd0) ? 7'd1 : cfg_i.fps;

  // year mod 25 by reciprocal; quotient may be one short, so one correction
  always_comb begin
    prod    = 26'(cur_i.year) * 26'd2621;
    quo     = prod[25:16];
    quo25   = 14'({quo, 4'b0}) + 14'({quo, 3'b0}) + 14'(quo);
    rem_raw = cur_i.year - quo25;
    rem     = (rem_raw[5:0] >= 6'd25) ? rem_raw[5:0] - 6'd25 : rem_raw[5:0];
    leap    = (cur_i.year[1:0] == 2'd0) && ((rem != 6'd0) || (cur_i.year[3:0] == 4'd0));
  end

  always_comb begin
    t       = cur_i;
    wrap    = 1'b0;
    f_inc   = 8'(cur_i.frame) + 8'd1;
    s_inc   = 7'(cur_i.second) + 7'd1;
    m_inc   = 7'(cur_i.minute) + 7'd1;
    h_inc   = 6'(cur_i.hour) + 6'd1;
    d_inc   = 6'(cur_i.day) + 6'd1;
    mo_inc  = 5'(cur_i.month) + 5'd1;
    mo_sum  = 5'(cur_i.month) + 5'd10;
    mo_back = 4'd1;
    skip    = cfg_i.drop && !min_tens(cur_i.minute) && (cur_i.second == 6'd0) &&
              (cur_i.frame == 7'd2);
    unique case (req_i)
      REQ_FWD: begin
        if (f_inc >= 8'(rate)) begin
          t.frame = '0;
          if (s_inc >= 7'd60) begin
            t.second = '0;
            if (m_inc >= 7'd60) begin
              t.minute = '0;
              if (h_inc >= 6'd24) begin
                t.hour = '0;
                wrap   = 1'b1;
              end else begin
                t.hour = h_inc[4:0];
              end
            end else begin
              t.minute = m_inc[5:0];
            end
          end else begin
            t.second = s_inc[5:0];
          end
        end else begin
          t.frame = f_inc[6:0];
        end
        if (cfg_i.drop && !min_tens(t.minute) && t.second == 6'd0 && t.frame == 7'd0) begin
          t.frame = 7'd2;
        end
        if (wrap) begin
          if (d_inc > 6'(days_in(cur_i.month, leap))) begin
            t.day = 5'd1;
            if (mo_inc > 5'd12) begin
              t.month = 4'd1;
              t.year  = (cur_i.year >= YEAR_MAX) ? '0 : cur_i.year + 14'd1;
            end else begin
              t.month = mo_inc[3:0];
            end
          end else begin
            t.day = d_inc[4:0];
          end
        end
      end
      REQ_BACK: begin
        if (!skip && cur_i.frame != 7'd0) begin
          t.frame = cur_i.frame - 7'd1;
        end else begin
          t.frame = rate - 7'd1;
          if (cur_i.second != 6'd0) begin
            t.second = cur_i.second - 6'd1;
          end else begin
            t.second = 6'd59;
            if (cur_i.minute != 6'd0) begin
              t.minute = cur_i.minute - 6'd1;
            end else begin
              t.minute = 6'd59;
              if (cur_i.hour != 5'd0) begin
                t.hour = cur_i.hour - 5'd1;
              end else begin
                t.hour = 5'd23;
                wrap   = 1'b1;
              end
            end
          end
        end
        if (wrap) begin
          if (cur_i.day > 5'd1) begin
            t.day = cur_i.day - 5'd1;
          end else begin
            if (mo_sum >= 5'd24) mo_back = 4'(mo_sum - 5'd23);
            else if (mo_sum >= 5'd12) mo_back = 4'(mo_sum - 5'd11);
            else mo_back = 4'(mo_sum + 5'd1);
            t.month = mo_back;
            t.day   = days_in(mo_back, leap);
            if (mo_back == 4'd12) begin
              t.year = (cur_i.year == 14'd0) ? YEAR_MAX : cur_i.year - 14'd1;
            end
          end
        end
      end
      REQ_LOAD: t = load_i;
      REQ_NONE: t = cur_i;
      default:  t = cur_i;
    endcase
  end

  assign nxt_o   = t;
  assign carry_o = wrap;

endmodule

FILE: sv/timecode_datetime_counter.sv
// Timecode and calendar counter. Each input beat loads a time and date, steps one frame
// forward or one frame back, or holds them; each beat yields exactly one output beat carrying
// the new time, date and a day carry flag. A beat is captured in an input register and its
// result is written to the output register once the output is free or being taken, so one
// beat is accepted every cycle while the output is not stalled, with the combinational step
// logic (frame to date carry chain and the leap-year test) between the two registers.
// One further input beat is still accepted while a result waits at the output. Configuration
// writes are always ready and take effect on the next step; out of reset the rate is 30
// frames per second, drop frame off, time 00:00:00:00 and date 2000-01-01.
module timecode_datetime_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // load_hour, load_minute, load_second, load_frame, load_year, load_month, load_day, pad
  input  logic [47:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hour, minute, second, frame, year, month, day, pad
  output logic [47:0] m_axis_tdata,
  // day_carry
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import tdc_pkg::*;

  logic      in_valid_q;
  req_e      in_req_q;
  tc_state_t in_load_q;
  logic      out_valid_q;
  tc_state_t out_state_q;
  logic      out_carry_q;
  tc_state_t state_q;
  tc_state_t state_d;
  logic      carry_d;
  tc_cfg_t   cfg_q;
  logic      advance;
  logic      s_beat;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fps  <= 7'd30;
      cfg_q.drop <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FPS) cfg_q.fps <= cfg_data_i[6:0];
      else if (cfg_index_i == CFG_DROP) cfg_q.drop <= cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_beat) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_req_q  <= req_e'(s_axis_tuser);
      in_load_q <= tc_state_t'(s_axis_tdata[46:0]);
    end
  end

  tdc_step u_step (
    .cur_i   (state_q),
    .req_i   (in_req_q),
    .load_i  (in_load_q),
    .cfg_i   (cfg_q),
    .nxt_o   (state_d),
    .carry_o (carry_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.hour   <= '0;
      state_q.minute <= '0;
      state_q.second <= '0;
      state_q.frame  <= '0;
      state_q.year   <= YEAR_RESET;
      state_q.month  <= 4'd1;
      state_q.day    <= 5'd1;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_state_q <= state_d;
      out_carry_q <= carry_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_state_q};
  assign m_axis_tuser  = out_carry_q;

endmodule

FILE: sv/tdc_checker.sv
`include "timecode_datetime_counter_macros.svh"

module tdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [3:0]  cfg_index_i,
  input logic [7:0]  cfg_data_i
);

  logic midnight;
  logic last_second;

  assign midnight    = (m_axis_tdata[16:0] == 17'd0);
  assign last_second = (m_axis_tdata[4:0] == 5'd23) && (m_axis_tdata[10:5] == 6'd59) &&
                       (m_axis_tdata[16:11] == 6'd59);

  // stalled result beat holds
  `TDC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed under stall")

  // day carry only at a midnight crossing
  `TDC_ASSERT(a_carry_time, m_axis_tvalid && m_axis_tuser[0] |-> midnight || last_second, "day carry without midnight crossing")

  // empty output never blocks the input side
  `TDC_ASSERT(a_in_ready, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

  // nothing valid straight out of reset
  `TDC_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind timecode_datetime_counter tdc_checker u_tdc_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import tdc_pkg::*;

  localparam logic [3:0] CFG_UNUSED = 4'd15;
  localparam int N_PHASES = 9;
  localparam int PHASE_FPS [N_PHASES] = '{30, 0, 1, 127, 120, 25, 60, 24, 29};
  localparam int PHASE_DROP [N_PHASES] = '{1, 0, 1, 1, 0, 0, 1, 1, 1};
  localparam int RUN_ITEMS = 75;

  typedef struct {
    req_e      req;
    tc_state_t ld;
  } tc_req_t;

  typedef struct {
    tc_state_t st;
    logic      carry;
  } tc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  // predictor copy of the registers and counters
  int unsigned fps_reg = 30;
  int unsigned drop_reg = 0;
  int unsigned t_hour = 0, t_min = 0, t_sec = 0, t_frm = 0;
  int unsigned d_year = 2000, d_mon = 1, d_day = 1;

  tc_req_t    req_q[$];
  tc_result_t timecode_q[$];

  int unsigned err_count = 0;
  int unsigned res_count = 0;
  int unsigned queued = 0;
  int unsigned src_gap = 0;
  int unsigned sink_hold = 0;
  bit          src_fire = 1'b0;
  bit          long_hold_done = 1'b0;
  bit          calm = 1'b0;

  timecode_datetime_counter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned eff_rate();
    return (fps_reg == 0) ? 1 : fps_reg;
  endfunction

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_len(int unsigned m, int unsigned y);
    if (m < 1 || m > 12) return 31;
    if (m == 2 && leap_year(y)) return 29;
    return MONTH_DAYS[m - 1];
  endfunction

  function automatic bit at_drop_point();
    return drop_reg != 0 && (t_min % 10) != 0 && t_sec == 0;
  endfunction

  function automatic void advance_date();
    int unsigned lim;
    lim = month_len(d_mon, d_year);
    d_day++;
    if (d_day > lim) begin
      d_day = 1;
      d_mon++;
      if (d_mon > 12) begin
        d_mon = 1;
        d_year = (d_year >= YEAR_MAX) ? 0 : d_year + 1;
      end
    end
  endfunction

  function automatic void retreat_date();
    int unsigned y;
    y = d_year;
    if (d_day > 1) begin
      d_day--;
      return;
    end
    d_mon = 1 + ((d_mon + 10) % 12);
    d_day = month_len(d_mon, y);
    if (d_mon == 12) d_year = (d_year == 0) ? YEAR_MAX : d_year - 1;
  endfunction

  function automatic bit advance_time();
    bit wrap;
    wrap = 1'b0;
    t_frm++;
    if (t_frm >= eff_rate()) begin
      t_frm = 0;
      t_sec++;
      if (t_sec >= 60) begin
        t_sec = 0;
        t_min++;
        if (t_min >= 60) begin
          t_min = 0;
          t_hour++;
          if (t_hour >= 24) begin
            t_hour = 0;
            wrap = 1'b1;
          end
        end
      end
    end
    if (at_drop_point() && t_frm == 0) t_frm = 2;
    return wrap;
  endfunction

  function automatic bit retreat_time();
    bit skip;
    skip = at_drop_point() && t_frm == 2;
    if (!skip && t_frm > 0) begin
      t_frm--;
      return 1'b0;
    end
    t_frm = eff_rate() - 1;
    if (t_sec > 0) begin
      t_sec--;
      return 1'b0;
    end
    t_sec = 59;
    if (t_min > 0) begin
      t_min--;
      return 1'b0;
    end
    t_min = 59;
    if (t_hour > 0) begin
      t_hour--;
      return 1'b0;
    end
    t_hour = 23;
    return 1'b1;
  endfunction

  function automatic tc_result_t step_timecode(req_e req, tc_state_t ld);
    tc_result_t res;
    logic       carry;
    carry = 1'b0;
    case (req)
      REQ_FWD: begin
        if (advance_time()) begin
          advance_date();
          carry = 1'b1;
        end
      end
      REQ_BACK: begin
        if (retreat_time()) begin
          retreat_date();
          carry = 1'b1;
        end
      end
      REQ_LOAD: begin
        t_hour = 32'(ld.hour);
        t_min  = 32'(ld.minute);
        t_sec  = 32'(ld.second);
        t_frm  = 32'(ld.frame);
        d_year = 32'(ld.year);
        d_mon  = 32'(ld.month);
        d_day  = 32'(ld.day);
      end
      default: ;
    endcase
    res.st.hour   = 5'(t_hour);
    res.st.minute = 6'(t_min);
    res.st.second = 6'(t_sec);
    res.st.frame  = 7'(t_frm);
    res.st.year   = 14'(d_year);
    res.st.month  = 4'(d_mon);
    res.st.day    = 5'(d_day);
    res.carry     = carry;
    return res;
  endfunction

  function automatic tc_state_t mk_state(int h, int mi, int s, int f, int y, int mo, int d);
    tc_state_t st;
    st.hour   = 5'(h);
    st.minute = 6'(mi);
    st.second = 6'(s);
    st.frame  = 7'(f);
    st.year   = 14'(y);
    st.month  = 4'(mo);
    st.day    = 5'(d);
    return st;
  endfunction

  function automatic tc_state_t rand_state();
    bit [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[46:0];
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch on %s at result %0d: got %0d, expected %0d", what, res_count, got,
               want);
  endtask

  task automatic push_req(req_e req, tc_state_t ld);
    tc_req_t item;
    item.req = req;
    item.ld  = ld;
    req_q.push_back(item);
    if (req != REQ_NONE) queued++;
  endtask

  task automatic write_reg(logic [3:0] idx, logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_FPS) fps_reg = 32'(data & 8'h7f);
    else if (idx == CFG_DROP) drop_reg = 32'(data & 8'h01);
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || s_axis_tvalid || timecode_q.size() != 0) @(posedge clk_i);
  endtask

  // an optional load (near the wraps, in range, or raw bits), then a run of steps or mixed requests
  task automatic queue_random_run();
    tc_state_t   ld;
    int unsigned r, mode, y, mo, len;
    bit          edgy, mixed;
    req_e        dir;
    r = eff_rate();
    mode = $urandom_range(0, 99);
    edgy = mode < 55;
    if (mode < 10) begin
      push_req(REQ_LOAD, rand_state());
    end else if (mode < 85) begin
      if (edgy) begin
        case ($urandom_range(0, 5))
          0: y = 0;
          1: y = YEAR_MAX;
          2: y = 2000;
          3: y = 1900;
          4: y = 4 * $urandom_range(0, 2499);
          default: y = $urandom_range(0, 9999);
        endcase
        case ($urandom_range(0, 3))
          0: mo = 1;
          1: mo = 2;
          2: mo = 12;
          default: mo = $urandom_range(1, 12);
        endcase
        ld.day = 5'($urandom_range(0, 1) ? month_len(mo, y) : 1);
        ld.hour = 5'($urandom_range(0, 1) ? 23 : 0);
        case ($urandom_range(0, 3))
          0: ld.minute = 6'd59;
          1: ld.minute = 6'(10 * $urandom_range(0, 5) + 9);
          2: ld.minute = 6'(10 * $urandom_range(0, 5) + $urandom_range(0, 1));
          default: ld.minute = 6'($urandom_range(0, 59));
        endcase
        ld.second = 6'($urandom_range(0, 1) ? 59 : 0);
        ld.frame = 7'($urandom_range(0, 1) ? r - 1 :
                      $urandom_range(0, (r > 3) ? 3 : r - 1));
      end else begin
        y = $urandom_range(0, 9999);
        mo = $urandom_range(1, 12);
        ld.day = 5'($urandom_range(1, month_len(mo, y)));
        ld.hour = 5'($urandom_range(0, 23));
        ld.minute = 6'($urandom_range(0, 59));
        ld.second = 6'($urandom_range(0, 59));
        ld.frame = 7'($urandom_range(0, r - 1));
      end
      ld.year = 14'(y);
      ld.month = 4'(mo);
      push_req(REQ_LOAD, ld);
    end
    len = $urandom_range(1, 40);
    dir = $urandom_range(0, 1) ? REQ_FWD : REQ_BACK;
    mixed = $urandom_range(0, 9) == 0;
    repeat (len) begin
      if (mixed) push_req(req_e'($urandom_range(0, 3)), rand_state());
      else push_req(dir, rand_state());
    end
  endtask

  // sender
  always @(negedge clk_i) begin : drv
    tc_req_t item;
    if (rst_ni && (!s_axis_tvalid || src_fire)) begin
      if (src_gap != 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() != 0) begin
        item = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= item.req;
        s_axis_tdata  <= {1'b0, item.ld};
        if (!calm && $urandom_range(0, 15) == 0) src_gap = $urandom_range(1, 18);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && res_count >= 80) begin
        long_hold_done = 1'b1;
        sink_hold = 250;
      end
      if (sink_hold != 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        sink_hold = $urandom_range(0, 17);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor: check result beats, predict on accepted input beats
  always @(posedge clk_i) begin : mon
    tc_result_t want;
    tc_state_t  got;
    src_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_count++;
      got = m_axis_tdata[46:0];
      if (timecode_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = timecode_q.pop_front();
        if (got.hour !== want.st.hour) report_mismatch("hour", got.hour, want.st.hour);
        if (got.minute !== want.st.minute)
          report_mismatch("minute", got.minute, want.st.minute);
        if (got.second !== want.st.second)
          report_mismatch("second", got.second, want.st.second);
        if (got.frame !== want.st.frame) report_mismatch("frame", got.frame, want.st.frame);
        if (got.year !== want.st.year) report_mismatch("year", got.year, want.st.year);
        if (got.month !== want.st.month) report_mismatch("month", got.month, want.st.month);
        if (got.day !== want.st.day) report_mismatch("day", got.day, want.st.day);
        if (m_axis_tuser[0] !== want.carry)
          report_mismatch("day_carry", m_axis_tuser[0], want.carry);
      end
    end
    if (src_fire)
      timecode_q.push_back(step_timecode(req_e'(s_axis_tuser), s_axis_tdata[46:0]));
  end

  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stim
    bit [7:0] wd;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // out of reset: 30 fps, no drop
    push_req(REQ_FWD, rand_state());
    push_req(REQ_BACK, rand_state());
    push_req(REQ_BACK, rand_state());
    push_req(REQ_FWD, rand_state());
    push_req(REQ_NONE, rand_state());
    push_req(REQ_LOAD, mk_state(23, 59, 59, 29, 2000, 2, 28));
    push_req(REQ_FWD, rand_state());
    push_req(REQ_LOAD, mk_state(23, 59, 59, 29, 1900, 2, 28));
    push_req(REQ_FWD, rand_state());
    push_req(REQ_LOAD, mk_state(23, 59, 59, 29, 9999, 12, 31));
    push_req(REQ_FWD, rand_state());
    push_req(REQ_LOAD, mk_state(0, 0, 0, 0, 0, 1, 1));
    push_req(REQ_BACK, rand_state());
    push_req(REQ_LOAD, mk_state(0, 0, 0, 0, 2000, 3, 1));
    push_req(REQ_BACK, rand_state());
    push_req(REQ_LOAD, '1);
    push_req(REQ_FWD, rand_state());
    push_req(REQ_LOAD, '1);
    push_req(REQ_BACK, rand_state());
    push_req(REQ_LOAD, mk_state(0, 0, 0, 0, 2000, 0, 1));
    push_req(REQ_BACK, rand_state());
    push_req(REQ_LOAD, mk_state(0, 0, 0, 0, 2000, 13, 1));
    push_req(REQ_BACK, rand_state());

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      if (p == N_PHASES - 1) calm = 1'b1;
      wd = 8'($urandom);
      wd[6:0] = 7'(PHASE_FPS[p]);
      write_reg(CFG_FPS, wd);
      wd = 8'($urandom);
      wd[0] = PHASE_DROP[p][0];
      write_reg(CFG_DROP, wd);
      if (p == 2) write_reg(CFG_UNUSED, 8'($urandom));
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
      if (p == 0) begin
        // drop frame: skip on entry to minute 1, none at minute 10
        push_req(REQ_LOAD, mk_state(0, 0, 59, 29, 2024, 6, 15));
        push_req(REQ_FWD, rand_state());
        push_req(REQ_BACK, rand_state());
        push_req(REQ_LOAD, mk_state(0, 9, 59, 29, 2024, 6, 15));
        push_req(REQ_FWD, rand_state());
        push_req(REQ_LOAD, mk_state(0, 1, 0, 1, 2024, 6, 15));
        push_req(REQ_BACK, rand_state());
      end
      queued = 0;
      while (queued < RUN_ITEMS) queue_random_run();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
